// ===== rtl/dspv_pkg.sv =====
// dspv_pkg: shared constants, types and the month-length table of the date parser.
// No dependencies; imported by the top level, dspv_parser, dspv_check and the bench files.
package dspv_pkg;

    localparam int NUM_FIELDS = 5;
    localparam int CNT_W      = 3;

    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;

    localparam logic [3:0] MON_FEB = 4'd2;
    localparam logic [3:0] MON_APR = 4'd4;
    localparam logic [3:0] MON_JUN = 4'd6;
    localparam logic [3:0] MON_SEP = 4'd9;
    localparam logic [3:0] MON_NOV = 4'd11;

    localparam int YEAR_MIN  = 1000;
    localparam int YEAR_MAX  = 9999;
    localparam int MONTH_MAX = 12;
    localparam int HOURS     = 24;
    localparam int MINUTES   = 60;

    typedef logic [3:0] digit_t;

    typedef struct packed {
        logic full;
        logic yr_hund;
    } dspv_flags_t;

    typedef struct packed {
        logic        valid_res;
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
    } dspv_res_t;

    function automatic logic [4:0] month_len(input logic [3:0] mo, input logic leap);
        logic [4:0] len;
        if (mo == MON_FEB)
        begin
            len = leap ? 5'd29 : 5'd28;
        end
        else if (mo == MON_APR || mo == MON_JUN || mo == MON_SEP || mo == MON_NOV)
        begin
            len = 5'd30;
        end
        else
        begin
            len = 5'd31;
        end
        return len;
    endfunction

endpackage

// ===== rtl/dspv_if.sv =====
// Valid/ready channel interfaces for the date parser: character in, result out.
// Depends on nothing.
interface dspv_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       last_char;

    modport source (output valid, output char_code, output last_char, input ready);
    modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

interface dspv_out_if;
    logic        valid;
    logic        ready;
    logic        valid_res;
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;

    modport source (output valid, output valid_res, output year, output month,
                    output day, output hour, output minute, input ready);
    modport sink   (input valid, input valid_res, input year, input month,
                    input day, input hour, input minute, output ready);
endinterface

// ===== rtl/date_string_parse_validate.sv =====
// date_string_parse_validate: top level of the date-time string parser and validator.
// Depends on dspv_pkg, dspv_if, dspv_parser and dspv_check.
//
//   channel   dir   beat                                  payload
//   char_in   in    one character                         char_code, last_char
//   res_out   out   one result per last character         valid_res, year .. minute
//
// One character per cycle sustained unless a stalled result backs up to the parser; the parser updates on every step.
// A last character's beat reaches its result through the field snapshot register, then the result register.
// Pipeline: input register, field snapshot register, result register.
// A stalled result backs up only once a later last character reaches the parser.
// Reset clears all valid bits and the parse state.
module date_string_parse_validate #(
    parameter int ACC_WIDTH = 16
) (
    input logic          clk,
    input logic          rst_n,
    dspv_in_if.sink      char_in,
    dspv_out_if.source   res_out
);
    import dspv_pkg::*;

    logic                 s0_vld_reg;
    logic [7:0]           s0_char_reg;
    logic                 s0_last_reg;
    logic                 s1_vld_reg;
    logic [ACC_WIDTH-1:0] s1_num_reg [NUM_FIELDS];
    dspv_flags_t          s1_flags_reg;
    logic                 res_vld_reg;
    dspv_res_t            res_reg;

    logic                 out_free;
    logic                 s1_free;
    logic                 step;
    logic                 in_ready;
    logic [ACC_WIDTH-1:0] snap_num [NUM_FIELDS];
    dspv_flags_t          snap_flags;
    dspv_res_t            chk_res;

    assign out_free = !res_vld_reg || res_out.ready;
    assign s1_free  = !s1_vld_reg || out_free;
    assign step     = s0_vld_reg && (!s0_last_reg || s1_free);
    assign in_ready = !s0_vld_reg || step;

    dspv_parser #(.ACC_WIDTH(ACC_WIDTH)) u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .char_code  (s0_char_reg),
        .last_char  (s0_last_reg),
        .snap_num   (snap_num),
        .snap_flags (snap_flags)
    );

    dspv_check #(.ACC_WIDTH(ACC_WIDTH)) u_check (
        .num   (s1_num_reg),
        .flags (s1_flags_reg),
        .res   (chk_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_vld_reg  <= 1'b0;
            s1_vld_reg  <= 1'b0;
            res_vld_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                s0_vld_reg <= char_in.valid;
            end
            if (s1_free)
            begin
                s1_vld_reg <= step && s0_last_reg;
            end
            if (out_free)
            begin
                res_vld_reg <= s1_vld_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && char_in.valid)
        begin
            s0_char_reg <= char_in.char_code;
            s0_last_reg <= char_in.last_char;
        end
        if (step && s0_last_reg)
        begin
            s1_num_reg   <= snap_num;
            s1_flags_reg <= snap_flags;
        end
        if (out_free && s1_vld_reg)
        begin
            res_reg <= chk_res;
        end
    end

    assign char_in.ready     = in_ready;
    assign res_out.valid     = res_vld_reg;
    assign res_out.valid_res = res_reg.valid_res;
    assign res_out.year      = res_reg.year;
    assign res_out.month     = res_reg.month;
    assign res_out.day       = res_reg.day;
    assign res_out.hour      = res_reg.hour;
    assign res_out.minute    = res_reg.minute;

endmodule

// ===== rtl/dspv_parser.sv =====
// dspv_parser: digit-run accumulator and field store, one character per step.
// Depends on dspv_pkg.
module dspv_parser #(
    parameter int ACC_WIDTH = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   step,
    input  logic [7:0]             char_code,
    input  logic                   last_char,
    output logic [ACC_WIDTH-1:0]   snap_num [dspv_pkg::NUM_FIELDS],
    output dspv_pkg::dspv_flags_t  snap_flags
);
    import dspv_pkg::*;

    localparam int WIDE_W = ACC_WIDTH + 4;

    logic [ACC_WIDTH-1:0] acc_reg;
    logic                 run_reg;
    logic [CNT_W-1:0]     cnt_reg;
    digit_t               dig_lo_reg;
    digit_t               dig_hi_reg;
    logic                 yr_hund_reg;
    logic [ACC_WIDTH-1:0] num_reg [NUM_FIELDS];

    logic                 is_digit;
    digit_t               digit;
    logic [WIDE_W-1:0]    wide;
    logic [ACC_WIDTH-1:0] sat;
    logic [ACC_WIDTH-1:0] cur_acc;
    logic                 cur_run;
    digit_t               cur_lo;
    digit_t               cur_hi;
    logic                 close;
    logic                 store;
    logic [CNT_W-1:0]     cnt_upd;
    logic                 yr_upd;
    logic [ACC_WIDTH-1:0] num_upd [NUM_FIELDS];

    always_comb
    begin
        is_digit = (char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE);
        digit    = char_code[3:0];
        wide     = ({4'b0, acc_reg} << 3) + ({4'b0, acc_reg} << 1)
                 + WIDE_W'(digit);
        sat      = (wide[WIDE_W-1:ACC_WIDTH] != 4'b0) ? {ACC_WIDTH{1'b1}}
                                                     : wide[ACC_WIDTH-1:0];
        cur_acc  = is_digit ? sat : acc_reg;
        cur_run  = is_digit || run_reg;
        cur_lo   = is_digit ? digit : dig_lo_reg;
        cur_hi   = is_digit ? dig_lo_reg : dig_hi_reg;
        close    = !is_digit || last_char;
        store    = close && cur_run && (cnt_reg < CNT_W'(NUM_FIELDS));
        cnt_upd  = cnt_reg + CNT_W'(store);
        yr_upd   = (store && cnt_reg == '0) ? (cur_lo == '0 && cur_hi == '0)
                                            : yr_hund_reg;
        for (int i = 0; i < NUM_FIELDS; i++)
        begin
            num_upd[i] = (store && cnt_reg == CNT_W'(i)) ? cur_acc : num_reg[i];
        end
        snap_num           = num_upd;
        snap_flags.full    = (cnt_upd == CNT_W'(NUM_FIELDS));
        snap_flags.yr_hund = yr_upd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg     <= '0;
            run_reg     <= 1'b0;
            cnt_reg     <= '0;
            dig_lo_reg  <= '0;
            dig_hi_reg  <= '0;
            yr_hund_reg <= 1'b0;
        end
        else if (step)
        begin
            if (last_char)
            begin
                acc_reg     <= '0;
                run_reg     <= 1'b0;
                cnt_reg     <= '0;
                dig_lo_reg  <= '0;
                dig_hi_reg  <= '0;
                yr_hund_reg <= 1'b0;
            end
            else
            begin
                acc_reg     <= close ? '0 : cur_acc;
                run_reg     <= close ? 1'b0 : cur_run;
                dig_lo_reg  <= close ? '0 : cur_lo;
                dig_hi_reg  <= close ? '0 : cur_hi;
                cnt_reg     <= cnt_upd;
                yr_hund_reg <= yr_upd;
            end
        end
    end

    // field store is payload: only used for a valid result once all five entries were written
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            num_reg <= num_upd;
        end
    end

endmodule

// ===== rtl/dspv_check.sv =====
// dspv_check: range and calendar checks on the five parsed fields, zeroing on failure.
// Depends on dspv_pkg.
module dspv_check #(
    parameter int ACC_WIDTH = 16
) (
    input  logic [ACC_WIDTH-1:0]  num [dspv_pkg::NUM_FIELDS],
    input  dspv_pkg::dspv_flags_t flags,
    output dspv_pkg::dspv_res_t   res
);
    import dspv_pkg::*;

    logic [ACC_WIDTH-1:0] y;
    logic [ACC_WIDTH-1:0] mo;
    logic [ACC_WIDTH-1:0] d;
    logic [ACC_WIDTH-1:0] h;
    logic [ACC_WIDTH-1:0] mi;
    logic                 leap;
    logic [4:0]           mlen;
    logic                 ok;

    always_comb
    begin
        y  = num[0];
        mo = num[1];
        d  = num[2];
        h  = num[3];
        mi = num[4];
        // divisible by 100 from the last two decimal digits; by 400 then needs 16
        leap = (y[1:0] == 2'b0) && (!flags.yr_hund || y[3:0] == 4'b0);
        mlen = month_len(mo[3:0], leap);
        ok   = flags.full
            && (y >= ACC_WIDTH'(YEAR_MIN)) && (y <= ACC_WIDTH'(YEAR_MAX))
            && (h < ACC_WIDTH'(HOURS)) && (mi < ACC_WIDTH'(MINUTES))
            && (mo != '0) && (mo <= ACC_WIDTH'(MONTH_MAX))
            && (d != '0) && (d <= ACC_WIDTH'(mlen));
        res.valid_res = ok;
        res.year      = ok ? y[13:0] : '0;
        res.month     = ok ? mo[3:0] : '0;
        res.day       = ok ? d[4:0]  : '0;
        res.hour      = ok ? h[4:0]  : '0;
        res.minute    = ok ? mi[5:0] : '0;
    end

endmodule

// ===== rtl/dspv_checker.sv =====
// dspv_checker: port-level assertions for date_string_parse_validate, with its bind.
// Depends on the top level's channel ports only.
module dspv_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic        valid_res,
    input logic [13:0] year,
    input logic [3:0]  month,
    input logic [4:0]  day,
    input logic [4:0]  hour,
    input logic [5:0]  minute
);

    // stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable({valid_res, year, month,
                                                          day, hour, minute}))
        else $error("result beat changed while stalled");

    // input backs up only behind a stalled result
    a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without output back-pressure");

    a_valid_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && valid_res |-> year >= 14'd1000 && year <= 14'd9999
            && month >= 4'd1 && month <= 4'd12 && day >= 5'd1
            && hour < 5'd24 && minute < 6'd60)
        else $error("valid result out of range");

    a_feb_day: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && valid_res && month == 4'd2 |-> day <= 5'd29)
        else $error("february day too large");

    a_zero_fail: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !valid_res |-> year == 14'd0 && month == 4'd0 && day == 5'd0
            && hour == 5'd0 && minute == 6'd0)
        else $error("failed result not zeroed");

endmodule

bind date_string_parse_validate dspv_checker u_dspv_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (char_in.ready),
    .out_valid (res_out.valid),
    .out_ready (res_out.ready),
    .valid_res (res_out.valid_res),
    .year      (res_out.year),
    .month     (res_out.month),
    .day       (res_out.day),
    .hour      (res_out.hour),
    .minute    (res_out.minute)
);

// ===== bench/dspv_checker.sv =====
`timescale 1ns / 100ps
// dspv_scoreboard: watches both channels of the date parser, predicts each result and compares.
// Depends on dspv_pkg and dspv_if; hands its failure count and pending count to the bench top.
module dspv_scoreboard #(
    parameter int ACC_WIDTH = 16
) (
    input  logic clk,
    input  logic rst_n,
    dspv_in_if   char_in,
    dspv_out_if  res_out,
    output int   fail_count,
    output int   pending
);
    import dspv_pkg::*;

    localparam longint unsigned RUN_MAX = (64'd1 << ACC_WIDTH) - 64'd1;

    logic [ACC_WIDTH-1:0] run_value;
    logic                 run_open;
    int unsigned          fields_seen;
    logic [ACC_WIDTH-1:0] fields [NUM_FIELDS];
    dspv_res_t            expected_dates[$];

    function automatic bit is_leap_year(input longint unsigned y);
        return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
    endfunction

    function automatic longint unsigned days_in(input longint unsigned y,
                                                 input longint unsigned m);
        if (m == MON_FEB)
        begin
            return is_leap_year(y) ? 29 : 28;
        end
        if (m == MON_APR || m == MON_JUN || m == MON_SEP || m == MON_NOV)
        begin
            return 30;
        end
        return 31;
    endfunction

    function automatic bit date_ok(input longint unsigned y, input longint unsigned mo,
                                   input longint unsigned d, input longint unsigned h,
                                   input longint unsigned mi);
        if (y < YEAR_MIN || y > YEAR_MAX)
        begin
            return 1'b0;
        end
        if (h >= HOURS || mi >= MINUTES)
        begin
            return 1'b0;
        end
        if (mo == 0 || mo > MONTH_MAX)
        begin
            return 1'b0;
        end
        if (d == 0 || d > days_in(y, mo))
        begin
            return 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic clear_parse();
        run_value   = '0;
        run_open    = 1'b0;
        fields_seen = 0;
        foreach (fields[i])
        begin
            fields[i] = '0;
        end
    endtask

    task automatic close_run();
        if (run_open)
        begin
            if (fields_seen < NUM_FIELDS)
            begin
                fields[fields_seen] = run_value;
                fields_seen++;
            end
            run_value = '0;
            run_open  = 1'b0;
        end
    endtask

    task automatic predict_char(input logic [7:0] c, input logic last);
        longint unsigned v;
        dspv_res_t       r;
        if (c >= CHAR_ZERO && c <= CHAR_NINE)
        begin
            v         = longint'(run_value) * 10 + longint'(c - CHAR_ZERO);
            run_value = (v > RUN_MAX) ? RUN_MAX[ACC_WIDTH-1:0] : v[ACC_WIDTH-1:0];
            run_open  = 1'b1;
        end
        else
        begin
            close_run();
        end
        if (last)
        begin
            close_run();
            r = '0;
            if (fields_seen >= NUM_FIELDS &&
                date_ok(fields[0], fields[1], fields[2], fields[3], fields[4]))
            begin
                r.valid_res = 1'b1;
                r.year      = fields[0][13:0];
                r.month     = fields[1][3:0];
                r.day       = fields[2][4:0];
                r.hour      = fields[3][4:0];
                r.minute    = fields[4][5:0];
            end
            expected_dates = {expected_dates, r};
            clear_parse();
        end
    endtask

    task automatic check_field(input string name, input longint unsigned e,
                               input longint unsigned a);
        if (e != a)
        begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, e, a);
            fail_count++;
        end
    endtask

    initial
    begin
        fail_count = 0;
        pending    = 0;
        clear_parse();
    end

    always @(posedge clk or negedge rst_n)
    begin
        dspv_res_t want;
        if (!rst_n)
        begin
            clear_parse();
            expected_dates.delete();
            pending = 0;
        end
        else
        begin
            if (res_out.valid && res_out.ready)
            begin
                if (expected_dates.size() == 0)
                begin
                    $display("%0t: extra result: expected none, actual %0d %0d/%0d/%0d %0d:%0d",
                             $time, res_out.valid_res, res_out.year, res_out.month,
                             res_out.day, res_out.hour, res_out.minute);
                    fail_count++;
                end
                else
                begin
                    want = expected_dates.pop_front();
                    check_field("valid_res", want.valid_res, res_out.valid_res);
                    check_field("year", want.year, res_out.year);
                    check_field("month", want.month, res_out.month);
                    check_field("day", want.day, res_out.day);
                    check_field("hour", want.hour, res_out.hour);
                    check_field("minute", want.minute, res_out.minute);
                end
            end
            if (char_in.valid && char_in.ready)
            begin
                predict_char(char_in.char_code, char_in.last_char);
            end
            pending = expected_dates.size();
        end
    end

endmodule

// ===== bench/tb_date_string_parse_validate.sv =====
`timescale 1ns / 100ps
// tb_date_string_parse_validate: drives date strings into the parser and stalls its result side.
// Depends on dspv_pkg, dspv_if, the block and dspv_scoreboard; gives the verdict.
module tb_date_string_parse_validate;
    import dspv_pkg::*;

    localparam int IDLE_LIMIT   = 1000;
    localparam int TARGET_CHARS = 550;
    localparam int MIN_STRINGS  = 30;

    logic       clk;
    logic       rst_n;
    int         fail_count;
    int         pending;
    int         idle_cycles;
    int         chars_sent;
    int         strings_sent;
    bit         feed_quiet;
    bit         drain_quiet;
    logic [7:0] text[$];

    dspv_in_if  char_in ();
    dspv_out_if res_out ();

    date_string_parse_validate #(.ACC_WIDTH(16)) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .char_in (char_in),
        .res_out (res_out)
    );

    dspv_scoreboard #(.ACC_WIDTH(16)) u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_in    (char_in),
        .res_out    (res_out),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((char_in.valid && char_in.ready) || (res_out.valid && res_out.ready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // result side: random stall before each result beat, none while drain_quiet is set
    initial
    begin
        int stall;
        res_out.ready = 1'b0;
        drain_quiet   = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                drain_quiet = ~drain_quiet;
            end
            stall = drain_quiet ? 0 : $urandom_range(0, 15);
            if (stall > 0)
            begin
                res_out.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            res_out.ready <= 1'b1;
            do @(posedge clk); while (!(res_out.valid && res_out.ready));
            @(negedge clk);
        end
    end

    task automatic send_beat(input logic [7:0] c, input logic last);
        int gap;
        gap = feed_quiet ? 0 : $urandom_range(0, 15);
        if (gap > 0)
        begin
            char_in.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        char_in.valid     <= 1'b1;
        char_in.char_code <= c;
        char_in.last_char <= last;
        do @(posedge clk); while (!char_in.ready);
        chars_sent++;
        @(negedge clk);
    endtask

    task automatic send_text();
        if ($urandom_range(0, 3) == 0)
        begin
            feed_quiet = ~feed_quiet;
        end
        for (int i = 0; i < text.size(); i++)
        begin
            send_beat(text[i], i == text.size() - 1);
        end
        text.delete();
        strings_sent++;
    endtask

    task automatic add_byte(input logic [7:0] b);
        text = {text, b};
    endtask

    task automatic put_string(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            add_byte(s[i]);
        end
    endtask

    task automatic put_num(input longint unsigned v);
        if ($urandom_range(0, 5) == 0)
        begin
            repeat ($urandom_range(1, 2)) add_byte(CHAR_ZERO);
        end
        put_string($sformatf("%0d", v));
    endtask

    task automatic put_sep();
        string      seps;
        logic [7:0] b;
        seps = "-/: T.";
        case ($urandom_range(0, 9))
            6, 7, 8:
            begin
                do b = 8'($urandom_range(0, 255)); while (b >= CHAR_ZERO && b <= CHAR_NINE);
                add_byte(b);
            end
            9:
            begin
                add_byte(seps[$urandom_range(0, 5)]);
                add_byte(seps[$urandom_range(0, 5)]);
            end
            default:
            begin
                add_byte(seps[$urandom_range(0, 5)]);
            end
        endcase
    endtask

    task automatic make_random_text();
        longint unsigned vals[7];
        longint unsigned huge_years[6];
        int              nf;
        int              k;
        huge_years = '{1000, 9999, 10000, 65535, 65536, 999999999};
        if ($urandom_range(0, 9) == 0)
        begin
            repeat ($urandom_range(1, 12)) add_byte(8'($urandom_range(0, 255)));
            return;
        end
        k = $urandom_range(0, 9);
        case (k)
            5:       vals[0] = 64'($urandom_range(10, 99) * 100);
            6:       vals[0] = 64'($urandom_range(250, 2499) * 4);
            7:       vals[0] = 64'($urandom_range(0, 999));
            8:       vals[0] = 64'($urandom_range(10000, 99999));
            9:       vals[0] = huge_years[$urandom_range(0, 5)];
            default: vals[0] = 64'($urandom_range(1000, 9999));
        endcase
        vals[1] = ($urandom_range(0, 4) != 0) ? 64'($urandom_range(1, 12))
                                              : 64'($urandom_range(0, 1) * 13);
        if ($urandom_range(0, 9) == 0)
        begin
            vals[1] = 99;
        end
        k = $urandom_range(0, 19);
        if (k < 13)
        begin
            vals[2] = 64'($urandom_range(1, 31));
        end
        else if (k < 17)
        begin
            vals[2] = 64'($urandom_range(28, 31));
        end
        else
        begin
            vals[2] = (k == 17) ? 0 : ((k == 18) ? 32 : 99);
        end
        vals[3] = ($urandom_range(0, 6) != 0) ? 64'($urandom_range(0, 23))
                                              : 64'($urandom_range(24, 99));
        vals[4] = ($urandom_range(0, 6) != 0) ? 64'($urandom_range(0, 59))
                                              : 64'($urandom_range(60, 100));
        vals[5] = 64'($urandom_range(0, 999));
        vals[6] = 64'($urandom_range(0, 99999));
        k = $urandom_range(0, 9);
        nf = (k < 8) ? 5 : ((k == 8) ? $urandom_range(6, 7) : $urandom_range(0, 4));
        for (int f = 0; f < nf; f++)
        begin
            if (f > 0 || $urandom_range(0, 7) == 0)
            begin
                put_sep();
            end
            put_num(vals[f]);
        end
        if (text.size() == 0 || $urandom_range(0, 1) == 0)
        begin
            put_sep();
        end
    endtask

    initial
    begin
        rst_n             = 1'b0;
        char_in.valid     = 1'b0;
        char_in.char_code = '0;
        char_in.last_char = 1'b0;
        idle_cycles       = 0;
        chars_sent        = 0;
        strings_sent      = 0;
        feed_quiet        = 1'b0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        // empty string with a high-bit byte, leap day at the last minute of the day, saturating run
        add_byte(8'hFF);
        send_text();
        put_string("2000/2/29 23:59");
        send_text();
        put_string("99999999");
        send_text();

        while (chars_sent < TARGET_CHARS || strings_sent < MIN_STRINGS)
        begin
            make_random_text();
            send_text();
        end
        char_in.valid <= 1'b0;

        while (pending != 0) @(negedge clk);
        repeat (8) @(negedge clk);
        if (fail_count == 0 && pending == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ===== date_string_parse_validate.f =====
rtl/dspv_pkg.sv
rtl/dspv_if.sv
rtl/dspv_parser.sv
rtl/dspv_check.sv
rtl/date_string_parse_validate.sv
rtl/dspv_checker.sv
bench/dspv_checker.sv
bench/tb_date_string_parse_validate.sv
